[design/bfha_pkg.sv]
`timescale 1ns / 1ps
package bfha_pkg;

	localparam int CMD_W   = 2;
	localparam int REQ_W   = 13;
	localparam int ADDR_W  = 12;
	localparam int STAT_W  = 2;
	localparam int BYTES_W = 13;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_FIT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

	localparam int ALIGN_BYTES     = 4;
	localparam int SPLIT_MIN_BYTES = 8;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
		logic shift;
		logic wr_a;
		logic wr_b;
		logic out_load;
	} bfha_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic plan_write;
		logic plan_shift;
		logic split;
		logic shift_done;
	} bfha_stat_t;

endpackage

[design/bfha_req_if.sv]
`timescale 1ns / 1ps
interface bfha_req_if;
	import bfha_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [REQ_W-1:0]    request_size;
	logic [ADDR_W-1:0]   free_address;

	modport source (output valid, output command, output request_size, output free_address,
		input ready);
	modport sink (input valid, input command, input request_size, input free_address,
		output ready);
endinterface

[design/bfha_rsp_if.sv]
`timescale 1ns / 1ps
interface bfha_rsp_if;
	import bfha_pkg::*;
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [ADDR_W-1:0]   payload_address;
	logic [BYTES_W-1:0]  free_bytes;
	logic [BYTES_W-1:0]  used_bytes;
	logic [BYTES_W-1:0]  peak_bytes;

	modport source (output valid, output status, output payload_address, output free_bytes,
		output used_bytes, output peak_bytes, input ready);
	modport sink (input valid, input status, input payload_address, input free_bytes,
		input used_bytes, input peak_bytes, output ready);
endinterface

[design/best_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// Best-fit heap allocator with coalescing over an address-ordered block table held in a
// single-port-write, single-port-read memory. Each transaction on req (allocate, free or
// query) gives one transaction on rsp with status, payload offset and the free, used and peak
// byte counts. An item walks the table once, one entry per cycle; an allocate that splits or
// a free that merges then moves the entries above the chosen block by one entry per cycle.
// A new request is taken while a finished response still waits in the output register.
module best_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 12,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bfha_req_if.sink   req,
	bfha_rsp_if.source rsp
);
	import bfha_pkg::*;

	bfha_cmd_t  cmd;
	bfha_stat_t stat;

	bfha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bfha_dp #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.command         (req.command),
		.request_size    (req.request_size),
		.free_address    (req.free_address),
		.status          (rsp.status),
		.payload_address (rsp.payload_address),
		.free_bytes      (rsp.free_bytes),
		.used_bytes      (rsp.used_bytes),
		.peak_bytes      (rsp.peak_bytes)
	);
endmodule

[design/bfha_ctrl.sv]
`timescale 1ns / 1ps
module bfha_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  bfha_pkg::bfha_stat_t stat,
	output bfha_pkg::bfha_cmd_t  cmd
);
	import bfha_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_WR_A,
		S_WR_B,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && req_valid;
		cmd.scan     = (state_q == S_SCAN);
		cmd.decide   = (state_q == S_DECIDE);
		cmd.shift    = (state_q == S_SHIFT);
		cmd.wr_a     = (state_q == S_WR_A);
		cmd.wr_b     = (state_q == S_WR_B);
		cmd.out_load = (state_q == S_FIN) && (!out_valid_q || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					priority if (!stat.plan_write) begin
						state_q <= S_FIN;
					end else if (stat.plan_shift) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_WR_A;
					end
				end
				S_SHIFT: begin
					if (stat.shift_done) begin
						state_q <= S_WR_A;
					end
				end
				S_WR_A: begin
					state_q <= stat.split ? S_WR_B : S_FIN;
				end
				S_WR_B: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[design/bfha_dp.sv]
`timescale 1ns / 1ps
module bfha_dp #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 12,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfha_pkg::bfha_cmd_t           cmd,
	output bfha_pkg::bfha_stat_t          stat,
	input  logic [bfha_pkg::CMD_W-1:0]    command,
	input  logic [bfha_pkg::REQ_W-1:0]    request_size,
	input  logic [bfha_pkg::ADDR_W-1:0]   free_address,
	output logic [bfha_pkg::STAT_W-1:0]   status,
	output logic [bfha_pkg::ADDR_W-1:0]   payload_address,
	output logic [bfha_pkg::BYTES_W-1:0]  free_bytes,
	output logic [bfha_pkg::BYTES_W-1:0]  used_bytes,
	output logic [bfha_pkg::BYTES_W-1:0]  peak_bytes
);
	import bfha_pkg::*;

	localparam int PW = $clog2(HEAP_BYTES + 1);
	localparam int XW = ((PW > REQ_W) ? PW : REQ_W) + 2;
	localparam int EW = PW + 1;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	localparam logic [XW-1:0] HDR       = XW'(HEADER_BYTES);
	localparam logic [XW-1:0] HEAPX     = XW'(HEAP_BYTES);
	localparam logic [XW-1:0] SPLIT_MIN = XW'(SPLIT_MIN_BYTES);
	localparam logic [XW-1:0] ALIGN_M1  = XW'(ALIGN_BYTES - 1);
	localparam logic [CW-1:0] MAXC      = CW'(MAX_BLOCKS);
	localparam logic [EW-1:0] INIT_ENT  = {1'b1, PW'(HEAP_BYTES - HEADER_BYTES)};

	logic [EW-1:0] mem [MAX_BLOCKS];
	logic          w0_q;

	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     used_q, peak_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [XW-1:0]     need_q;
	logic [ADDR_W-1:0] faddr_q;

	logic [CW-1:0] rd_idx_q;
	logic          vld_s1, shv_s1;
	logic [CW-1:0] idx_s1;
	logic [EW-1:0] rdata_s1;

	logic [XW-1:0] pos_q;
	logic [EW-1:0] prev_q;
	logic          found_q;
	logic [CW-1:0] best_idx_q;
	logic [XW-1:0] best_size_q, best_pos_q;
	logic          hit_q, want_next_q, next_valid_q;
	logic [CW-1:0] hit_idx_q;
	logic [EW-1:0] hit_ent_q, hprev_q, next_q;

	logic [CW-1:0] sh_src_q, sh_left_q;
	logic          sh_up_q;
	logic [1:0]    sh_r_q;
	logic          split_q;
	logic [CW-1:0] wa_addr_q, wb_addr_q;
	logic [EW-1:0] wa_data_q, wb_data_q;
	logic [STAT_W-1:0] res_status_q;
	logic [ADDR_W-1:0] res_addr_q;

	// read port
	logic          scan_rd, shift_rd, rd_en;
	logic [CW-1:0] rd_addr;
	assign scan_rd  = cmd.scan && (rd_idx_q < cnt_q);
	assign shift_rd = cmd.shift && (sh_left_q != '0);
	assign rd_en    = scan_rd || shift_rd;
	assign rd_addr  = shift_rd ? sh_src_q : rd_idx_q;

	// write port
	logic          wr_en;
	logic [CW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wa_addr_q;
		wr_data = wa_data_q;
		priority if (vld_s1 && shv_s1) begin
			wr_en   = 1'b1;
			wr_addr = sh_up_q ? (idx_s1 + CW'(1)) : (idx_s1 - CW'(sh_r_q));
			wr_data = rdata_s1;
		end else if (cmd.wr_a) begin
			wr_en = 1'b1;
		end else if (cmd.wr_b) begin
			wr_en   = 1'b1;
			wr_addr = wb_addr_q;
			wr_data = wb_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= (rd_addr == '0 && !w0_q) ? INIT_ENT : mem[rd_addr[IW-1:0]];
		end
	end

	// scan view of the returned entry
	logic [XW-1:0] ent_size;
	logic          ent_free;
	assign ent_size = XW'(rdata_s1[PW-1:0]);
	assign ent_free = rdata_s1[PW];

	// decision
	logic          split_c, alloc_ok, free_ok, prev_fr, next_fr;
	logic [1:0]    r_c;
	logic [CW-1:0] target_c, sh_left_c, sh_src_c;
	logic [XW-1:0] merged_c, used_new_c;
	always_comb begin
		split_c  = (best_size_q >= need_q + HDR + SPLIT_MIN) && (cnt_q < MAXC);
		alloc_ok = (cmd_q == CMD_ALLOC) && found_q;
		free_ok  = (cmd_q == CMD_FREE) && (faddr_q != '0) && hit_q && !hit_ent_q[PW];
		prev_fr  = (hit_idx_q != '0) && hprev_q[PW];
		next_fr  = next_valid_q && next_q[PW];
		r_c      = {1'b0, prev_fr} + {1'b0, next_fr};
		target_c = hit_idx_q - CW'(prev_fr);
		merged_c = (prev_fr ? (XW'(hprev_q[PW-1:0]) + HDR) : '0)
			+ XW'(hit_ent_q[PW-1:0])
			+ (next_fr ? (XW'(next_q[PW-1:0]) + HDR) : '0);
		sh_left_c  = '0;
		sh_src_c   = '0;
		used_new_c = XW'(used_q);
		if (alloc_ok) begin
			used_new_c = XW'(used_q) + (split_c ? need_q : best_size_q);
			sh_src_c   = cnt_q - CW'(1);
			if (split_c) begin
				sh_left_c = cnt_q - best_idx_q - CW'(1);
			end
		end else if (free_ok) begin
			used_new_c = XW'(used_q) - XW'(hit_ent_q[PW-1:0]);
			sh_src_c   = target_c + CW'(1) + CW'(r_c);
			if (r_c != '0) begin
				sh_left_c = cnt_q - target_c - CW'(1) - CW'(r_c);
			end
		end
	end

	assign stat.scan_done  = (rd_idx_q == cnt_q) && !vld_s1;
	assign stat.plan_write = alloc_ok || free_ok;
	assign stat.plan_shift = (alloc_ok || free_ok) && (sh_left_c != '0);
	assign stat.split      = split_q;
	assign stat.shift_done = (sh_left_q == '0) && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q      <= 1'b0;
			cnt_q     <= CW'(1);
			used_q    <= '0;
			peak_q    <= '0;
			vld_s1    <= 1'b0;
			rd_idx_q  <= '0;
			sh_left_q <= '0;
		end else begin
			if (wr_en && wr_addr == '0) begin
				w0_q <= 1'b1;
			end
			vld_s1 <= rd_en;
			if (scan_rd) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (cmd.load) begin
				rd_idx_q <= '0;
			end
			if (shift_rd) begin
				sh_left_q <= sh_left_q - CW'(1);
			end
			if (cmd.decide) begin
				sh_left_q <= sh_left_c;
				used_q    <= PW'(used_new_c);
				if (used_new_c > XW'(peak_q)) begin
					peak_q <= PW'(used_new_c);
				end
				if (alloc_ok && split_c) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (free_ok) begin
					cnt_q <= cnt_q - CW'(r_c);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			shv_s1 <= shift_rd;
			idx_s1 <= rd_addr;
		end
		if (shift_rd) begin
			sh_src_q <= sh_up_q ? (sh_src_q - CW'(1)) : (sh_src_q + CW'(1));
		end
		if (cmd.load) begin
			cmd_q        <= command;
			need_q       <= (XW'(request_size) + ALIGN_M1) & ~ALIGN_M1;
			faddr_q      <= free_address;
			pos_q        <= '0;
			prev_q       <= '0;
			found_q      <= 1'b0;
			hit_q        <= 1'b0;
			want_next_q  <= 1'b0;
			next_valid_q <= 1'b0;
		end else if (vld_s1 && !shv_s1) begin
			pos_q  <= pos_q + HDR + ent_size;
			prev_q <= rdata_s1;
			if (ent_free && ent_size >= need_q && (!found_q || ent_size < best_size_q)) begin
				found_q     <= 1'b1;
				best_idx_q  <= idx_s1;
				best_size_q <= ent_size;
				best_pos_q  <= pos_q;
			end
			if (!hit_q && (pos_q + HDR == XW'(faddr_q))) begin
				hit_q       <= 1'b1;
				hit_idx_q   <= idx_s1;
				hit_ent_q   <= rdata_s1;
				hprev_q     <= prev_q;
				want_next_q <= 1'b1;
			end else if (want_next_q) begin
				next_q       <= rdata_s1;
				next_valid_q <= 1'b1;
				want_next_q  <= 1'b0;
			end
		end
		if (cmd.decide) begin
			split_q    <= alloc_ok && split_c;
			sh_src_q   <= sh_src_c;
			sh_up_q    <= alloc_ok;
			sh_r_q     <= r_c;
			res_addr_q <= '0;
			if (alloc_ok) begin
				wa_addr_q    <= best_idx_q;
				wa_data_q    <= {1'b0, PW'(split_c ? need_q : best_size_q)};
				wb_addr_q    <= best_idx_q + CW'(1);
				wb_data_q    <= {1'b1, PW'(best_size_q - need_q - HDR)};
				res_status_q <= ST_OK;
				res_addr_q   <= ADDR_W'(best_pos_q + HDR);
			end else if (free_ok) begin
				wa_addr_q    <= target_c;
				wa_data_q    <= {1'b1, PW'(merged_c)};
				res_status_q <= ST_OK;
			end else if (cmd_q == CMD_ALLOC) begin
				res_status_q <= ST_NO_FIT;
			end else if (cmd_q == CMD_FREE && faddr_q != '0) begin
				res_status_q <= ST_BAD_FREE;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (cmd.out_load) begin
			status          <= res_status_q;
			payload_address <= res_addr_q;
			free_bytes      <= BYTES_W'(HEAPX - HDR * XW'(cnt_q) - XW'(used_q));
			used_bytes      <= BYTES_W'(XW'(used_q));
			peak_bytes      <= BYTES_W'(XW'(peak_q));
		end
	end
endmodule

[design/bfha_checker.sv]
`timescale 1ns / 1ps
module bfha_checker #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 12
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [bfha_pkg::STAT_W-1:0]   status,
	input logic [bfha_pkg::ADDR_W-1:0]   payload_address,
	input logic [bfha_pkg::BYTES_W-1:0]  free_bytes,
	input logic [bfha_pkg::BYTES_W-1:0]  used_bytes,
	input logic [bfha_pkg::BYTES_W-1:0]  peak_bytes
);
	import bfha_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(payload_address)
			&& $stable(used_bytes))
		else $error("response changed while stalled");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> payload_address == '0)
		else $error("failed transaction carries an address");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> peak_bytes >= used_bytes)
		else $error("peak below used");

	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(free_bytes) + int'(used_bytes) + HEADER_BYTES) <= HEAP_BYTES)
		else $error("free and used exceed heap");
endmodule

bind best_fit_heap_allocator bfha_checker #(
	.HEAP_BYTES   (HEAP_BYTES),
	.HEADER_BYTES (HEADER_BYTES)
) u_bfha_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.payload_address (rsp.payload_address),
	.free_bytes      (rsp.free_bytes),
	.used_bytes      (rsp.used_bytes),
	.peak_bytes      (rsp.peak_bytes)
);

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
	import bfha_pkg::*;

	localparam int HEAP   = 4096;
	localparam int HDR    = 12;
	localparam int NBLK   = 64;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ADDR_W-1:0]  payload_address;
		logic [BYTES_W-1:0] free_bytes;
		logic [BYTES_W-1:0] used_bytes;
		logic [BYTES_W-1:0] peak_bytes;
	} heap_result_t;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	bfha_req_if req ();
	bfha_rsp_if rsp ();

	best_fit_heap_allocator uut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	int unsigned  blk_size [NBLK];
	bit           blk_free [NBLK];
	int unsigned  blk_count;
	int unsigned  used_sum;
	int unsigned  peak_sum;
	heap_result_t results_due [$];
	int unsigned  live_addrs [$];
	int           errors = 0;
	bit           rsp_pause = 0;

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void drop_block(int unsigned idx);
		for (int unsigned i = idx; i + 1 < blk_count; i++) begin
			blk_size[i] = blk_size[i + 1];
			blk_free[i] = blk_free[i + 1];
		end
		blk_count--;
	endfunction

	function automatic heap_result_t heap_predict(logic [CMD_W-1:0] cmd,
			logic [REQ_W-1:0] size, logic [ADDR_W-1:0] faddr);
		heap_result_t res;
		int unsigned need, pos, best, best_size, best_pos, i, fsum;
		bit found;
		res = '0;
		res.status = ST_OK;
		if (cmd == CMD_ALLOC) begin
			need = (32'(size) + 32'd3) & ~32'd3;
			pos = 0; found = 0; best = 0; best_size = 0; best_pos = 0;
			for (i = 0; i < blk_count; i++) begin
				if (blk_free[i] && blk_size[i] >= need && (!found || blk_size[i] < best_size)) begin
					found = 1; best = i; best_size = blk_size[i]; best_pos = pos;
				end
				pos += HDR + blk_size[i];
			end
			if (!found) res.status = ST_NO_FIT;
			else begin
				if (best_size >= need + HDR + SPLIT_MIN_BYTES && blk_count < NBLK) begin
					for (i = blk_count; i > best + 1; i--) begin
						blk_size[i] = blk_size[i - 1];
						blk_free[i] = blk_free[i - 1];
					end
					blk_size[best + 1] = best_size - need - HDR;
					blk_free[best + 1] = 1;
					blk_size[best] = need;
					blk_count++;
				end
				blk_free[best] = 0;
				used_sum += blk_size[best];
				if (used_sum > peak_sum) peak_sum = used_sum;
				res.payload_address = ADDR_W'(best_pos + HDR);
			end
		end else if (cmd == CMD_FREE && faddr != 0) begin
			pos = 0;
			for (i = 0; i < blk_count; i++) begin
				if (pos + HDR == faddr) break;
				pos += HDR + blk_size[i];
			end
			if (i >= blk_count || blk_free[i]) res.status = ST_BAD_FREE;
			else begin
				blk_free[i] = 1;
				used_sum -= blk_size[i];
				if (i + 1 < blk_count && blk_free[i + 1]) begin
					blk_size[i] += blk_size[i + 1] + HDR;
					drop_block(i + 1);
				end
				if (i > 0 && blk_free[i - 1]) begin
					blk_size[i - 1] += blk_size[i] + HDR;
					drop_block(i);
				end
			end
		end
		fsum = 0;
		for (i = 0; i < blk_count; i++) if (blk_free[i]) fsum += blk_size[i];
		res.free_bytes = BYTES_W'(fsum);
		res.used_bytes = BYTES_W'(used_sum);
		res.peak_bytes = BYTES_W'(peak_sum);
		return res;
	endfunction

	task automatic send_command(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] size,
			logic [ADDR_W-1:0] faddr);
		heap_result_t res;
		int unsigned g;
		g = gap_len();
		if (g != 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1;
		req.command <= cmd;
		req.request_size <= size;
		req.free_address <= faddr;
		do @(posedge clk); while (!req.ready);
		res = heap_predict(cmd, size, faddr);
		results_due.push_back(res);
		if (cmd == CMD_ALLOC && res.status == ST_OK) live_addrs.push_back(res.payload_address);
		if (cmd == CMD_FREE && res.status == ST_OK && faddr != 0)
			foreach (live_addrs[k]) if (live_addrs[k] == faddr) begin
				live_addrs.delete(k);
				break;
			end
	endtask

	task automatic free_live();
		int unsigned k;
		if (live_addrs.size() == 0) send_command(CMD_FREE, REQ_W'($urandom), 0);
		else begin
			k = $urandom_range(0, live_addrs.size() - 1);
			send_command(CMD_FREE, REQ_W'($urandom), ADDR_W'(live_addrs[k]));
		end
	endtask

	always @(posedge clk) begin
		heap_result_t e;
		if (rsp.valid && rsp.ready) begin
			if (results_due.size() == 0) begin
				$error("unexpected transaction on rsp");
				errors++;
			end else begin
				e = results_due.pop_front();
				if (rsp.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp.status); errors++;
				end
				if (rsp.payload_address !== e.payload_address) begin
					$error("payload_address exp %0d got %0d", e.payload_address,
						rsp.payload_address); errors++;
				end
				if (rsp.free_bytes !== e.free_bytes) begin
					$error("free_bytes exp %0d got %0d", e.free_bytes, rsp.free_bytes); errors++;
				end
				if (rsp.used_bytes !== e.used_bytes) begin
					$error("used_bytes exp %0d got %0d", e.used_bytes, rsp.used_bytes); errors++;
				end
				if (rsp.peak_bytes !== e.peak_bytes) begin
					$error("peak_bytes exp %0d got %0d", e.peak_bytes, rsp.peak_bytes); errors++;
				end
			end
		end
	end

	initial begin
		int unsigned n;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			if (rsp_pause) rsp.ready <= 1;
			else begin
				n = gap_len();
				if (n != 0) begin
					rsp.ready <= 0;
					repeat (n) @(posedge clk);
				end
				rsp.ready <= 1;
				n = $urandom_range(1, 12);
			end
			repeat (rsp_pause ? 1 : n) @(posedge clk);
		end
	end

	task automatic test_directed();
		send_command(CMD_QUERY, 0, 0);
		send_command(2'd3, 13'h1fff, 12'hfff);
		send_command(CMD_FREE, 0, 0);
		send_command(CMD_FREE, 0, 12'hfff);
		send_command(CMD_FREE, 0, 12);
		send_command(CMD_ALLOC, 0, 0);
		send_command(CMD_ALLOC, 1, 0);
		send_command(CMD_ALLOC, 13'h1fff, 0);
		send_command(CMD_ALLOC, 4096, 0);
		send_command(CMD_ALLOC, 13, 0);
		send_command(CMD_FREE, 0, 13);
		send_command(CMD_FREE, 0, 12);
		send_command(CMD_FREE, 0, 12);
		while (live_addrs.size() > 0) free_live();
		send_command(CMD_ALLOC, REQ_W'(HEAP - HDR), 0);
		send_command(CMD_ALLOC, 0, 0);
		free_live();
		send_command(CMD_ALLOC, REQ_W'(HEAP - HDR - HDR - 4), 0);
		while (live_addrs.size() > 0) free_live();
	endtask

	task automatic test_full_table();
		// fill the table with small blocks until no split is possible
		for (int i = 0; i < 70; i++) send_command(CMD_ALLOC, REQ_W'($urandom_range(0, 40)), 0);
		send_command(CMD_ALLOC, 13'h0800, 0);
		send_command(CMD_ALLOC, 0, 0);
		for (int i = 0; i < 20; i++) free_live();
		for (int i = 0; i < 10; i++) send_command(CMD_ALLOC, REQ_W'($urandom_range(0, 64)), 0);
		while (live_addrs.size() > 0) free_live();
	endtask

	task automatic test_random();
		int unsigned r;
		for (int i = 0; i < 1300; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) send_command(CMD_ALLOC, REQ_W'(($urandom_range(0, 9) == 0) ?
				$urandom_range(0, 8191) : $urandom_range(0, 300)), 0);
			else if (r < 85) free_live();
			else if (r < 92) send_command(CMD_FREE, REQ_W'($urandom), ADDR_W'($urandom));
			else send_command(CMD_W'($urandom_range(2, 3)), REQ_W'($urandom),
				ADDR_W'($urandom));
			if (i % 200 == 199) while (live_addrs.size() > 0) free_live();
		end
	endtask

	initial begin
		req.valid = 0;
		req.command = CMD_QUERY;
		req.request_size = 0;
		req.free_address = 0;
		for (int i = 0; i < NBLK; i++) begin
			blk_size[i] = 0;
			blk_free[i] = 0;
		end
		blk_size[0] = HEAP - HDR;
		blk_free[0] = 1;
		blk_count = 1;
		used_sum = 0;
		peak_sum = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random();
		req.valid <= 0;
		rsp_pause = 1;
		while (results_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end
endmodule
